/* rtl/ahrd_pkg.sv */
// Shared types, character constants and codes for the AT HTTP response deframer.
package ahrd_pkg;

   localparam int MAX_SIZE_DIGITS = 11;
   localparam int WIN_LEN         = 5;
   localparam int MARK_LEN        = 12;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_K     = 8'h4B;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_R     = 8'h52;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_RESTART = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CONSUMED = 2'd0,
      KIND_PAYLOAD  = 2'd1,
      KIND_DONE     = 2'd2,
      KIND_ERROR    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_SCAN = 3'b001,
      PH_SIZE = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      FIN_RUN  = 3'b001,
      FIN_DONE = 3'b010,
      FIN_ERR  = 3'b100
   } finish_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload;
      logic        chunk_end;
      logic [31:0] byte_total;
   } rsp_type;

   typedef logic [WIN_LEN-1:0][7:0] window_type;

   typedef struct packed {
      window_type  win;
      logic [2:0]  count;
      logic [3:0]  marker_idx;
      logic        marker_full;
      logic        done;
      logic        err;
   } scan_result_type;

   function automatic logic [7:0] marker_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h2B; // '+'
         4'd1:    c = 8'h48; // 'H'
         4'd2:    c = 8'h54; // 'T'
         4'd3:    c = 8'h54; // 'T'
         4'd4:    c = 8'h50; // 'P'
         4'd5:    c = 8'h43; // 'C'
         4'd6:    c = 8'h4C; // 'L'
         4'd7:    c = 8'h49; // 'I'
         4'd8:    c = 8'h45; // 'E'
         4'd9:    c = 8'h4E; // 'N'
         4'd10:   c = 8'h54; // 'T'
         4'd11:   c = 8'h3A; // ':'
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* rtl/ahrd_scan.sv */
// Scan-mode matcher: shifts the recent-byte window and checks done, error and marker.
module ahrd_scan import ahrd_pkg::*; (
   input  window_type      win,
   input  logic [2:0]      count,
   input  logic [3:0]      marker_idx,
   input  logic [7:0]      rx_byte,
   output scan_result_type result
);

   window_type win_next;
   logic [2:0] count_next;
   logic       marker_ok;
   logic [3:0] idx_inc;

   always_comb begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
         win_next[i] = win[i+1];
      end
      win_next[WIN_LEN-1] = rx_byte;
   end

   assign count_next = (count < 3'(WIN_LEN)) ? count + 3'd1 : count;

   assign marker_ok = (marker_idx < 4'(MARK_LEN)) && (rx_byte == marker_char(marker_idx));
   assign idx_inc   = marker_idx + 4'd1;

   always_comb begin
      result.win   = win_next;
      result.count = count_next;
      result.done  = (count_next >= 3'd4) && (win_next[1] == CHAR_LF)
                     && (win_next[2] == CHAR_O) && (win_next[3] == CHAR_K)
                     && ((rx_byte == CHAR_CR) || (rx_byte == CHAR_LF));
      result.err   = (count_next == 3'(WIN_LEN)) && (win_next[0] == CHAR_E)
                     && (win_next[1] == CHAR_R) && (win_next[2] == CHAR_R)
                     && (win_next[3] == CHAR_O) && (win_next[4] == CHAR_R);
      if (marker_ok) begin
         result.marker_idx  = idx_inc;
         result.marker_full = (idx_inc == 4'(MARK_LEN));
      end else begin
         result.marker_idx  = (rx_byte == CHAR_PLUS) ? 4'd1 : 4'd0;
         result.marker_full = 1'b0;
      end
   end

endmodule

/* rtl/ahrd_engine.sv */
// Deframer state and the per-word update for scan, size and data modes.
module ahrd_engine import ahrd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   phase_type   phase_ff,      phase_in;
   finish_type  finish_ff,     finish_in;
   logic [3:0]  marker_ff,     marker_in;
   window_type  win_ff,        win_in;
   logic [2:0]  count_ff,      count_in;
   logic [31:0] acc_ff,        acc_in;
   logic [3:0]  digits_ff,     digits_in;
   logic [31:0] left_ff,       left_in;
   logic [31:0] total_ff,      total_in;

   scan_result_type scan;
   logic [35:0]     size_prod;
   logic [31:0]     left_dec;

   ahrd_scan u_scan (
      .win        (win_ff),
      .count      (count_ff),
      .marker_idx (marker_ff),
      .rx_byte    (item.rx_byte),
      .result     (scan)
   );

   // acc * 10 + digit, built from two shifts so no multiplier is needed.
   assign size_prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                      + {32'd0, item.rx_byte[3:0]};
   assign left_dec  = (left_ff != 32'd0) ? left_ff - 32'd1 : left_ff;

   always_comb begin
      phase_in  = phase_ff;
      finish_in = finish_ff;
      marker_in = marker_ff;
      win_in    = win_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      result    = '0;

      if (item.opcode == OP_RESTART) begin
         phase_in  = PH_SCAN;
         finish_in = FIN_RUN;
         marker_in = '0;
         win_in    = '0;
         count_in  = '0;
         acc_in    = '0;
         digits_in = '0;
         left_in   = '0;
         total_in  = '0;
      end else if (finish_ff == FIN_RUN) begin
         unique case (phase_ff)
            PH_SIZE: begin
               if (item.rx_byte == CHAR_COMMA) begin
                  left_in = acc_ff;
                  if (acc_ff == 32'd0) begin
                     phase_in  = PH_SCAN;
                     count_in  = '0;
                     marker_in = '0;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else if ((item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE)) begin
                  if (digits_ff < 4'(MAX_SIZE_DIGITS)) begin
                     acc_in    = (size_prod[35:32] != 4'd0) ? '1 : size_prod[31:0];
                     digits_in = digits_ff + 4'd1;
                  end
               end
            end
            PH_DATA: begin
               result.kind    = KIND_PAYLOAD;
               result.payload = item.rx_byte;
               if (total_ff != '1) begin
                  total_in = total_ff + 32'd1;
               end
               left_in = left_dec;
               if (left_dec == 32'd0) begin
                  result.chunk_end = 1'b1;
                  phase_in         = PH_SCAN;
                  count_in         = '0;
                  marker_in        = '0;
               end
            end
            PH_SCAN: begin
               win_in   = scan.win;
               count_in = scan.count;
               if (scan.done) begin
                  finish_in   = FIN_DONE;
                  result.kind = KIND_DONE;
               end else if (scan.err) begin
                  finish_in   = FIN_ERR;
                  result.kind = KIND_ERROR;
               end else if (scan.marker_full) begin
                  phase_in  = PH_SIZE;
                  marker_in = '0;
                  count_in  = '0;
                  acc_in    = '0;
                  digits_in = '0;
               end else begin
                  marker_in = scan.marker_idx;
               end
            end
            default: begin
               phase_in = PH_SCAN;
            end
         endcase
      end
      result.byte_total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SCAN;
         finish_ff <= FIN_RUN;
         marker_ff <= '0;
         win_ff    <= '0;
         count_ff  <= '0;
         acc_ff    <= '0;
         digits_ff <= '0;
         left_ff   <= '0;
         total_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         finish_ff <= finish_in;
         marker_ff <= marker_in;
         win_ff    <= win_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
      end
   end

endmodule

/* rtl/at_http_response_deframer_core.sv */
// Top level of the AT HTTP response deframer: input register, engine and result register.
// The deframer takes one modem word per clock while the result side does not stall and
// returns exactly one result word for each, in order. A word is captured in the input
// register, runs combinationally through the scan, size and data logic and lands in the
// result register, from which its result is offered on the outputs; absent a result-side
// stall, the sustained rate is one word per cycle. The only thing that slows intake is a
// stall on the result side, which backs up through the two registers. A restart word
// returns all state to its reset value and yields a consumed result with a zero byte
// total. After done or error is flagged, further modem words are consumed without effect
// until the next restart.
module at_http_response_deframer_core import ahrd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type step_result;
   logic    out_load;
   logic    step_en;
   logic    req_take;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = out_load ? in_valid_ff : rsp_valid_ff;
   end

   ahrd_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_data_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_chunk_end_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_end |-> rsp_data.kind == KIND_PAYLOAD)
      else $error("chunk end flagged on a word that is not payload");

   a_payload_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_PAYLOAD |-> rsp_data.byte_total != 32'd0)
      else $error("payload word delivered with a zero byte total");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && in_data_ff.opcode == OP_RESTART
      |=> rsp_valid && rsp_data.byte_total == 32'd0 && rsp_data.kind == KIND_CONSUMED)
      else $error("restart did not yield a cleared consumed result");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("input stalled while a register stage was free");

endmodule
